// ===== rtl/core/i2r_pkg.sv =====
package i2r_pkg;

    localparam int UPC_W     = 4;
    localparam int WEIGHT_W  = 10;
    localparam int VALUE_W   = 12;
    localparam int GLYPH_W   = 3;
    localparam int LETTER_W  = 8;

    localparam logic [VALUE_W-1:0] TOP_VALUE = 12'd4000;

    localparam logic [GLYPH_W-1:0] GL_I = 3'd0;
    localparam logic [GLYPH_W-1:0] GL_V = 3'd1;
    localparam logic [GLYPH_W-1:0] GL_X = 3'd2;
    localparam logic [GLYPH_W-1:0] GL_L = 3'd3;
    localparam logic [GLYPH_W-1:0] GL_C = 3'd4;
    localparam logic [GLYPH_W-1:0] GL_D = 3'd5;
    localparam logic [GLYPH_W-1:0] GL_M = 3'd6;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_ERR
    } seq_state_t;

    typedef struct packed {
        logic [WEIGHT_W-1:0] weight;
        logic [GLYPH_W-1:0]  glyph_a;
        logic [GLYPH_W-1:0]  glyph_b;
        logic                pair;
        logic [UPC_W-1:0]    hit_upc;
    } uword_t;

    typedef struct packed {
        logic                valid;
        logic [LETTER_W-1:0] letter;
        logic                last;
        logic                error;
    } emit_t;

    function automatic logic [LETTER_W-1:0] glyph_ascii(input logic [GLYPH_W-1:0] g);
        logic [LETTER_W-1:0] c;
        unique case (g)
            GL_I:    c = 8'h49;
            GL_V:    c = 8'h56;
            GL_X:    c = 8'h58;
            GL_L:    c = 8'h4C;
            GL_C:    c = 8'h43;
            GL_D:    c = 8'h44;
            GL_M:    c = 8'h4D;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/core/i2r_rom.sv =====
module i2r_rom
    import i2r_pkg::*;
(
    input  logic [UPC_W-1:0] upc,
    output uword_t           uword
);

    // weight, first glyph, second glyph, pair, target on hit
    always_comb begin
        unique case (upc)
            4'd0:    uword = '{10'd1000, GL_M, GL_M, 1'b0, 4'd0};
            4'd1:    uword = '{10'd900,  GL_C, GL_M, 1'b1, 4'd2};
            4'd2:    uword = '{10'd500,  GL_D, GL_D, 1'b0, 4'd3};
            4'd3:    uword = '{10'd400,  GL_C, GL_D, 1'b1, 4'd4};
            4'd4:    uword = '{10'd100,  GL_C, GL_C, 1'b0, 4'd4};
            4'd5:    uword = '{10'd90,   GL_X, GL_C, 1'b1, 4'd6};
            4'd6:    uword = '{10'd50,   GL_L, GL_L, 1'b0, 4'd7};
            4'd7:    uword = '{10'd40,   GL_X, GL_L, 1'b1, 4'd8};
            4'd8:    uword = '{10'd10,   GL_X, GL_X, 1'b0, 4'd8};
            4'd9:    uword = '{10'd9,    GL_I, GL_X, 1'b1, 4'd10};
            4'd10:   uword = '{10'd5,    GL_V, GL_V, 1'b0, 4'd11};
            4'd11:   uword = '{10'd4,    GL_I, GL_V, 1'b1, 4'd12};
            4'd12:   uword = '{10'd1,    GL_I, GL_I, 1'b0, 4'd12};
            default: uword = '{10'd1,    GL_I, GL_I, 1'b0, 4'd12};
        endcase
    end

endmodule

// ===== rtl/core/i2r_seq.sv =====
module i2r_seq
    import i2r_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [VALUE_W-1:0] number_value,
    input  logic               slot_free,
    output logic               idle,
    output emit_t              emit
);

    seq_state_t         state_reg, state_next;
    logic [UPC_W-1:0]   upc_reg, upc_next;
    logic               half_reg, half_next;
    logic [VALUE_W-1:0] value_reg, value_next;

    uword_t             uword;
    logic               ge;
    logic               in_bad;
    logic [VALUE_W-1:0] rem;

    i2r_rom u_rom (
        .upc   (upc_reg),
        .uword (uword)
    );

    assign ge     = value_reg >= {{(VALUE_W-WEIGHT_W){1'b0}}, uword.weight};
    assign rem    = value_reg - {{(VALUE_W-WEIGHT_W){1'b0}}, uword.weight};
    assign in_bad = (number_value == '0) || (number_value > TOP_VALUE);
    assign idle   = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = in_bad ? ST_ERR : ST_RUN;
                end
            end
            ST_RUN: begin
                if (slot_free && (half_reg || (ge && !uword.pair)) && (rem == '0)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_ERR: begin
                if (slot_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        emit       = '0;
        upc_next   = upc_reg;
        half_next  = half_reg;
        value_next = value_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    upc_next   = '0;
                    half_next  = 1'b0;
                    value_next = number_value;
                end
            end
            ST_RUN: begin
                if (half_reg) begin
                    emit.valid  = 1'b1;
                    emit.letter = glyph_ascii(uword.glyph_b);
                    emit.last   = (rem == '0);
                    if (slot_free) begin
                        half_next  = 1'b0;
                        value_next = rem;
                        upc_next   = uword.hit_upc;
                    end
                end else if (ge) begin
                    emit.valid  = 1'b1;
                    emit.letter = glyph_ascii(uword.glyph_a);
                    emit.last   = !uword.pair && (rem == '0);
                    if (slot_free) begin
                        if (uword.pair) begin
                            half_next = 1'b1;
                        end else begin
                            value_next = rem;
                            upc_next   = uword.hit_upc;
                        end
                    end
                end else begin
                    upc_next = upc_reg + UPC_W'(1);
                end
            end
            ST_ERR: begin
                emit.valid = 1'b1;
                emit.last  = 1'b1;
                emit.error = 1'b1;
            end
            default: emit = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            upc_reg   <= '0;
            half_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            upc_reg   <= upc_next;
            half_reg  <= half_next;
        end
        value_reg <= value_next;
    end

endmodule

// ===== rtl/core/integer_to_roman_numeral_top.sv =====
// Integer to Roman numeral converter.
// Input channel s_: one word carries a number in s_tdata[11:0]; it is taken
// only while no conversion is running (s_tready high when idle).
// Result channel m_: one word per numeral letter, most significant first,
// ASCII in m_tdata; m_tlast marks the final letter of the run. A number of
// zero or above 4000 gives a single word with m_tuser set, m_tdata zero and
// m_tlast set. 4000 gives MMMM.
// A microprogram of thirteen compare-subtract steps over the weights 1000,
// 900, 500 ... 1 drives one subtractor; a step whose weight exceeds the
// remaining value emits no letter and passes to the next step.
// The next number is taken as soon as the last letter sits in the output
// register.
// Reset (aresetn low, synchronous) drops any run in progress and empties the
// output register. When m_tready is low with a word in the output register,
// that word holds and the sequencer waits to emit its next letter.
module integer_to_roman_numeral_top
    import i2r_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [11:0] number_value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] letter
    output logic        m_tlast,
    output logic        m_tuser    // [0] error
);

    logic                m_tvalid_reg;
    logic [LETTER_W-1:0] m_tdata_reg;
    logic                m_tlast_reg;
    logic                m_tuser_reg;

    logic                idle;
    logic                slot_free;
    emit_t               emit;

    assign slot_free = !m_tvalid_reg || m_tready;
    assign s_tready  = idle;

    i2r_seq u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (s_tvalid && idle),
        .number_value (s_tdata[VALUE_W-1:0]),
        .slot_free    (slot_free),
        .idle         (idle),
        .emit         (emit)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (slot_free) begin
            m_tvalid_reg <= emit.valid;
        end
        if (slot_free && emit.valid) begin
            m_tdata_reg <= emit.letter;
            m_tlast_reg <= emit.last;
            m_tuser_reg <= emit.error;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== tb/tb_integer_to_roman_numeral_top.sv =====
module tb_integer_to_roman_numeral_top;
    import i2r_pkg::*;

    typedef struct packed {
        logic [LETTER_W-1:0] letter;
        logic                last;
        logic                error;
    } numeral_word_t;

    class roman_scoreboard;
        numeral_word_t numeral_q[$];
        int unsigned   faults = 0;

        function logic [LETTER_W-1:0] glyph_code(int unsigned idx);
            logic [LETTER_W-1:0] ch;
            case (idx)
                GL_I:    ch = "I";
                GL_V:    ch = "V";
                GL_X:    ch = "X";
                GL_L:    ch = "L";
                GL_C:    ch = "C";
                GL_D:    ch = "D";
                GL_M:    ch = "M";
                default: ch = 8'h00;
            endcase
            return ch;
        endfunction

        function void push_glyph(int unsigned idx);
            numeral_word_t w;
            w.letter = glyph_code(idx);
            w.last   = 1'b0;
            w.error  = 1'b0;
            numeral_q.push_back(w);
        endfunction

        // one-letter at lo, five-letter at lo + 1, ten-letter at lo + 2
        function void spell_digit(int unsigned d, int unsigned lo);
            int unsigned rest;
            rest = d;
            if (d == 9) begin
                push_glyph(lo);
                push_glyph(lo + 2);
                return;
            end
            if (d == 4) begin
                push_glyph(lo);
                push_glyph(lo + 1);
                return;
            end
            if (rest >= 5) begin
                push_glyph(lo + 1);
                rest = rest - 5;
            end
            for (int unsigned k = 0; k < rest; k++) begin
                push_glyph(lo);
            end
        endfunction

        function void note_number(logic [VALUE_W-1:0] value);
            int unsigned   v;
            numeral_word_t bad;
            v = value;
            if (v == 0 || v > TOP_VALUE) begin
                bad.letter = '0;
                bad.last   = 1'b1;
                bad.error  = 1'b1;
                numeral_q.push_back(bad);
                return;
            end
            for (int unsigned k = 0; k < v / 1000; k++) begin
                push_glyph(GL_M);
            end
            spell_digit((v / 100) % 10, GL_C);
            spell_digit((v / 10) % 10, GL_X);
            spell_digit(v % 10, GL_I);
            numeral_q[numeral_q.size() - 1].last = 1'b1;
        endfunction

        function void check_word(logic [LETTER_W-1:0] letter, logic last, logic error);
            numeral_word_t want;
            if (numeral_q.size() == 0) begin
                $error("unexpected word: letter %h last %b error %b", letter, last, error);
                faults++;
                return;
            end
            want = numeral_q.pop_front();
            if (letter !== want.letter) begin
                $error("letter: expected %h, got %h", want.letter, letter);
                faults++;
            end
            if (last !== want.last) begin
                $error("last: expected %b, got %b", want.last, last);
                faults++;
            end
            if (error !== want.error) begin
                $error("error: expected %b, got %b", want.error, error);
                faults++;
            end
        endfunction

        function int unsigned outstanding();
            return numeral_q.size();
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    bit quiet_in  = 1'b0;
    bit quiet_out = 1'b0;

    roman_scoreboard sb = new();

    integer_to_roman_numeral_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int unsigned draw_gap(bit quiet);
        return quiet ? 0 : $urandom_range(0, 11);
    endfunction

    function automatic logic [VALUE_W-1:0] pick_number();
        int unsigned sel;
        int unsigned v;
        sel = $urandom_range(0, 9);
        if (sel == 0) begin
            v = $urandom_range(0, 1) ? 0 : $urandom_range(4001, 4095);
        end else if (sel == 1) begin
            v = $urandom_range(3980, 4000);
        end else if (sel <= 4) begin
            v = $urandom_range(0, 3) * 1000 + $urandom_range(0, 9) * 100
                + $urandom_range(0, 9) * 10 + $urandom_range(0, 9);
            if (v == 0) begin
                v = $urandom_range(1, 9);
            end
        end else begin
            v = $urandom_range(1, 4000);
        end
        return v[VALUE_W-1:0];
    endfunction

    // enter and leave on a falling edge
    task automatic send_number(logic [VALUE_W-1:0] value);
        int unsigned gap;
        gap = draw_gap(quiet_in);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, value};
        do begin
            @(posedge aclk);
        end while (!s_tready);
        sb.note_number(value);
        @(negedge aclk);
    endtask

    task automatic take_word();
        int unsigned gap;
        gap = draw_gap(quiet_out);
        if (gap > 0) begin
            m_tready <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        m_tready <= 1'b1;
        do begin
            @(posedge aclk);
        end while (!(m_tvalid && m_tready));
        @(negedge aclk);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_word(m_tdata, m_tlast, m_tuser);
        end
    end

    initial begin
        @(posedge aresetn);
        @(negedge aclk);
        forever take_word();
    end

    initial begin
        int unsigned directed_values[$];
        directed_values = '{1, 4, 5, 9, 10, 40, 49, 90, 99, 400, 444, 900, 999, 1000,
                            3888, 3999, 4000, 4001, 0, 4095, 2048, 1994, 14, 3, 2744};
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        foreach (directed_values[i]) begin
            send_number(directed_values[i][VALUE_W-1:0]);
        end
        for (int chunk = 0; chunk < 7; chunk++) begin
            quiet_in  = (chunk % 4 == 1) || (chunk % 4 == 3);
            quiet_out = (chunk % 4 == 2) || (chunk % 4 == 3);
            repeat (34) send_number(pick_number());
        end
        quiet_in  = 1'b0;
        quiet_out = 1'b0;
        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (sb.faults == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #6000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
